// ----- rtl/core/mfb_pkg.sv -----
package mfb_pkg;

   // Default panel geometry.
   localparam int PANEL_WIDTH_DEF  = 128;
   localparam int PANEL_HEIGHT_DEF = 64;

   // Stream widths.
   localparam int REQ_DATA_W = 48;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 16;

   // Command codes carried in req_tuser.
   localparam logic [2:0] OP_PIXEL  = 3'd0;
   localparam logic [2:0] OP_LINE   = 3'd1;
   localparam logic [2:0] OP_FILL   = 3'd2;
   localparam logic [2:0] OP_INVERT = 3'd3;
   localparam logic [2:0] OP_READ   = 3'd4;

   localparam logic [7:0] BYTE_ZERO = 8'h00;
   localparam logic [7:0] BYTE_ONES = 8'hFF;

   // Sequencer commands to the line walker.
   typedef struct packed {
      logic load;
      logic step;
   } line_ctl_type;

endpackage

// ----- rtl/core/mfb_ram.sv -----
module mfb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule

// ----- rtl/core/mfb_line.sv -----
module mfb_line #(
   parameter int XW = 7,
   parameter int YW = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mfb_pkg::line_ctl_type ctl,
   input  logic [XW-1:0]        x0,
   input  logic [YW-1:0]        y0,
   input  logic [XW-1:0]        x1,
   input  logic [YW-1:0]        y1,
   output logic [XW-1:0]        x_out,
   output logic [YW-1:0]        y_out,
   output logic                 last
);

   localparam int EW = ((XW > YW) ? XW : YW) + 2;
   localparam logic signed [EW-1:0] ERR_ZERO = '0;

   logic [XW-1:0]        x_ff, xe_ff;
   logic [YW-1:0]        y_ff, ye_ff;
   logic                 sx_ff, sy_ff;
   logic signed [EW-1:0] dx_ff, dy_ff, err_ff;

   logic signed [EW-1:0] dx_ld, dy_ld, err_ld, err_in;
   logic                 step_x, step_y;

   always_comb begin
      dx_ld = (x1 >= x0) ? $signed(EW'(x1) - EW'(x0)) : $signed(EW'(x0) - EW'(x1));
      dy_ld = (y1 >= y0) ? $signed(EW'(y1) - EW'(y0)) : $signed(EW'(y0) - EW'(y1));
      // Initial error is half of the major delta, negative when y dominates or the deltas are equal.
      err_ld = (dx_ld > dy_ld) ? (dx_ld >>> 1) : -(dy_ld >>> 1);
      step_x = err_ff > -dx_ff;
      step_y = err_ff < dy_ff;
      err_in = err_ff - (step_x ? dy_ff : ERR_ZERO) + (step_y ? dx_ff : ERR_ZERO);
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         x_ff   <= x0;
         y_ff   <= y0;
         xe_ff  <= x1;
         ye_ff  <= y1;
         sx_ff  <= x1 > x0;
         sy_ff  <= y1 > y0;
         dx_ff  <= dx_ld;
         dy_ff  <= dy_ld;
         err_ff <= err_ld;
      end else if (ctl.step) begin
         err_ff <= err_in;
         if (step_x) begin
            x_ff <= sx_ff ? x_ff + XW'(1) : x_ff - XW'(1);
         end
         if (step_y) begin
            y_ff <= sy_ff ? y_ff + YW'(1) : y_ff - YW'(1);
         end
      end
   end

   assign x_out = x_ff;
   assign y_out = y_ff;
   assign last  = (x_ff == xe_ff) && (y_ff == ye_ff);

   a_no_step_past_end: assert property (@(posedge clock) disable iff (reset)
      ctl.step |-> !last) else $error("line walker stepped past its end point");

endmodule

// ----- rtl/core/monochrome_framebuffer_line_draw.sv -----
// One-bit-per-pixel page framebuffer with a Bresenham line walker. Pixel (x, y) is bit y%8 of
// byte x + (y/8)*PANEL_WIDTH in a single-port-per-direction byte RAM with a registered read.
// After reset a clearing pass writes zero to all PANEL_WIDTH*ceil(PANEL_HEIGHT/8) bytes, one
// per cycle (1024 bytes at the default 128x64 panel), and req_tready stays low until it ends.
// Each item is then worked alone: set pixel reads its byte and writes it back (nothing when
// rejected), a line does that read-modify-write for each plotted pixel, fill writes every
// store byte, toggle invert does a read-modify-write of every byte, and read byte reads one.
// One result follows every item; the next item is taken while the previous result still waits.
module monochrome_framebuffer_line_draw #(
   parameter int PANEL_WIDTH  = mfb_pkg::PANEL_WIDTH_DEF,
   parameter int PANEL_HEIGHT = mfb_pkg::PANEL_HEIGHT_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // x_start[7:0], y_start[14:8], x_end[22:15], y_end[29:23], pen_color[30],
   // byte_index[40:31], zero [47:41]
   input  logic [mfb_pkg::REQ_DATA_W-1:0] req_tdata,
   // op[2:0]
   input  logic [mfb_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // read_data[7:0], invert_active[8], pixel_rejected[9], zero [15:10]
   output logic [mfb_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int PAGES       = (PANEL_HEIGHT + 7) / 8;
   localparam int STORE_BYTES = PANEL_WIDTH * PAGES;
   localparam int AW          = $clog2(STORE_BYTES);
   localparam int XW          = $clog2(PANEL_WIDTH);
   localparam int YW          = $clog2(PANEL_HEIGHT);
   localparam logic [AW-1:0] CNT_LAST = AW'(STORE_BYTES - 1);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_START,
      S_PT_RD,
      S_PT_WR,
      S_FILL,
      S_INV_RD,
      S_INV_WR,
      S_RD_WAIT,
      S_DONE
   } state_type;

   state_type   state_ff;
   logic [AW-1:0] cnt_ff;
   logic        inv_ff;
   logic        rsp_valid_ff;
   logic [7:0]  rsp_data_ff;
   logic        rsp_inv_ff;
   logic        rsp_rej_ff;

   logic [2:0]  op_ff;
   logic [7:0]  xs_ff, xe_ff;
   logic [6:0]  ys_ff, ye_ff;
   logic        pen_ff;
   logic [9:0]  bidx_ff;
   logic        color_ff;
   logic [7:0]  fill_val_ff;
   logic [7:0]  res_data_ff;
   logic        res_rej_ff;

   logic        ram_we, ram_re;
   logic [AW-1:0] ram_waddr, ram_raddr, pix_addr;
   logic [7:0]  ram_wdata, ram_rdata, pix_mask;

   mfb_pkg::line_ctl_type line_ctl;
   logic [XW-1:0] lx0, lx1, wx;
   logic [YW-1:0] ly0, ly1, wy;
   logic        line_last;
   logic        reject;
   logic        read_in_range;
   logic        rsp_load;

   function automatic logic [XW-1:0] clamp_x(input logic [7:0] v);
      if ({1'b0, v} >= 9'(PANEL_WIDTH)) begin
         return XW'(PANEL_WIDTH - 1);
      end
      return v[XW-1:0];
   endfunction

   function automatic logic [YW-1:0] clamp_y(input logic [6:0] v);
      if ({1'b0, v} >= 8'(PANEL_HEIGHT)) begin
         return YW'(PANEL_HEIGHT - 1);
      end
      return v[YW-1:0];
   endfunction

   assign reject = ({1'b0, xs_ff} >= 9'(PANEL_WIDTH)) || ({1'b0, ys_ff} >= 8'(PANEL_HEIGHT));
   assign read_in_range = 32'(bidx_ff) < STORE_BYTES;
   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);

   // A pixel is a line whose end point is its start point.
   assign lx0 = clamp_x(xs_ff);
   assign ly0 = clamp_y(ys_ff);
   assign lx1 = (op_ff == mfb_pkg::OP_LINE) ? clamp_x(xe_ff) : lx0;
   assign ly1 = (op_ff == mfb_pkg::OP_LINE) ? clamp_y(ye_ff) : ly0;

   mfb_line #(
      .XW(XW),
      .YW(YW)
   ) u_line (
      .clock (clock),
      .reset (reset),
      .ctl   (line_ctl),
      .x0    (lx0),
      .y0    (ly0),
      .x1    (lx1),
      .y1    (ly1),
      .x_out (wx),
      .y_out (wy),
      .last  (line_last)
   );

   assign pix_addr = AW'(wx) + AW'(wy >> 3) * AW'(PANEL_WIDTH);
   assign pix_mask = 8'(1) << wy[2:0];

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = cnt_ff;
      ram_wdata = mfb_pkg::BYTE_ZERO;
      ram_re    = 1'b0;
      ram_raddr = cnt_ff;
      line_ctl  = '0;
      unique case (state_ff)
         S_CLEAR: begin
            ram_we = 1'b1;
         end
         S_START: begin
            line_ctl.load = (op_ff == mfb_pkg::OP_LINE) ||
                            ((op_ff == mfb_pkg::OP_PIXEL) && !reject);
            ram_re    = op_ff == mfb_pkg::OP_READ;
            ram_raddr = AW'(bidx_ff);
         end
         S_PT_RD: begin
            ram_re    = 1'b1;
            ram_raddr = pix_addr;
         end
         S_PT_WR: begin
            ram_we        = 1'b1;
            ram_waddr     = pix_addr;
            ram_wdata     = color_ff ? (ram_rdata | pix_mask) : (ram_rdata & ~pix_mask);
            line_ctl.step = !line_last;
         end
         S_FILL: begin
            ram_we    = 1'b1;
            ram_wdata = fill_val_ff;
         end
         S_INV_RD: begin
            ram_re = 1'b1;
         end
         S_INV_WR: begin
            ram_we    = 1'b1;
            ram_wdata = ~ram_rdata;
         end
         default: begin
         end
      endcase
   end

   mfb_ram #(
      .WIDTH(8),
      .DEPTH(STORE_BYTES)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         inv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               if (cnt_ff == CNT_LAST) begin
                  cnt_ff   <= '0;
                  state_ff <= S_IDLE;
               end else begin
                  cnt_ff <= cnt_ff + AW'(1);
               end
            end
            S_IDLE: begin
               if (req_tvalid) begin
                  op_ff    <= req_tuser[2:0];
                  xs_ff    <= req_tdata[7:0];
                  ys_ff    <= req_tdata[14:8];
                  xe_ff    <= req_tdata[22:15];
                  ye_ff    <= req_tdata[29:23];
                  pen_ff   <= req_tdata[30];
                  bidx_ff  <= req_tdata[40:31];
                  state_ff <= S_START;
               end
            end
            S_START: begin
               res_data_ff <= mfb_pkg::BYTE_ZERO;
               res_rej_ff  <= (op_ff == mfb_pkg::OP_PIXEL) && reject;
               color_ff    <= pen_ff ^ inv_ff;
               unique case (op_ff)
                  mfb_pkg::OP_PIXEL: begin
                     if (reject) begin
                        state_ff <= S_DONE;
                     end else begin
                        state_ff <= S_PT_RD;
                     end
                  end
                  mfb_pkg::OP_LINE: begin
                     state_ff <= S_PT_RD;
                  end
                  mfb_pkg::OP_FILL: begin
                     fill_val_ff <= pen_ff ? mfb_pkg::BYTE_ONES : mfb_pkg::BYTE_ZERO;
                     state_ff    <= S_FILL;
                  end
                  mfb_pkg::OP_INVERT: begin
                     inv_ff   <= ~inv_ff;
                     state_ff <= S_INV_RD;
                  end
                  mfb_pkg::OP_READ: begin
                     state_ff <= S_RD_WAIT;
                  end
                  default: begin
                     state_ff <= S_DONE;
                  end
               endcase
            end
            S_PT_RD: begin
               state_ff <= S_PT_WR;
            end
            S_PT_WR: begin
               state_ff <= line_last ? S_DONE : S_PT_RD;
            end
            S_FILL: begin
               if (cnt_ff == CNT_LAST) begin
                  cnt_ff   <= '0;
                  state_ff <= S_DONE;
               end else begin
                  cnt_ff <= cnt_ff + AW'(1);
               end
            end
            S_INV_RD: begin
               state_ff <= S_INV_WR;
            end
            S_INV_WR: begin
               if (cnt_ff == CNT_LAST) begin
                  cnt_ff   <= '0;
                  state_ff <= S_DONE;
               end else begin
                  cnt_ff   <= cnt_ff + AW'(1);
                  state_ff <= S_INV_RD;
               end
            end
            S_RD_WAIT: begin
               res_data_ff <= read_in_range ? ram_rdata : mfb_pkg::BYTE_ZERO;
               state_ff    <= S_DONE;
            end
            S_DONE: begin
               // The result register is loaded only once the previous item has left it.
               if (rsp_load) begin
                  rsp_data_ff  <= res_data_ff;
                  rsp_inv_ff   <= inv_ff;
                  rsp_rej_ff   <= res_rej_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_rej_ff, rsp_inv_ff, rsp_data_ff};

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !ram_we) else $error("store written while idle");

   a_idle_cnt_zero: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> cnt_ff == '0) else $error("sweep counter not rewound");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result raised outside the completion state");

endmodule
